### rtl/core/gesture_score_averager_assert.svh
// Assertion macros for the gesture score averager
`ifndef GESTURE_SCORE_AVERAGER_ASSERT_SVH
`define GESTURE_SCORE_AVERAGER_ASSERT_SVH

// clocked check, masked while reset is low
`define GSA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gsa assertion failed");

// clocked check that also holds through reset
`define GSA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("gsa assertion failed");

`endif

### rtl/core/gsa_pkg.sv
package gsa_pkg;

    localparam int SCORE_FIELDS = 4;
    localparam int SCORE_W      = 8;
    localparam int CFG_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int NONE_W       = 2;

    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_index_t;
    typedef logic [NONE_W-1:0]         class_code_t;

    localparam cfg_index_t CFG_DETECT_THRESHOLD = 2'd0;
    localparam cfg_index_t CFG_HOLDOFF_LENGTH   = 2'd1;
    localparam cfg_index_t CFG_NONE_CLASS       = 2'd2;

    localparam score_t         RST_DETECT_THRESHOLD = 8'sd80;
    localparam logic [7:0]     RST_HOLDOFF_LENGTH   = 8'd25;
    localparam class_code_t    RST_NONE_CLASS       = 2'd3;

    typedef struct packed {
        score_t      detect_threshold;
        logic [7:0]  holdoff_length;
        class_code_t none_class;
    } cfg_t;

endpackage

### rtl/core/gsa_if.sv
interface gsa_score_if
    import gsa_pkg::*;
();
    logic   valid;
    logic   ready;
    score_t score_0;
    score_t score_1;
    score_t score_2;
    score_t score_3;

    modport source (output valid, output score_0, output score_1, output score_2,
                    output score_3, input ready);
    modport sink   (input valid, input score_0, input score_1, input score_2,
                    input score_3, output ready);
endinterface

interface gsa_result_if
    import gsa_pkg::*;
();
    logic        valid;
    logic        ready;
    class_code_t gesture;
    score_t      best_average;
    logic        detected;

    modport source (output valid, output gesture, output best_average, output detected,
                    input ready);
    modport sink   (input valid, input gesture, input best_average, input detected,
                    output ready);
endinterface

### rtl/core/gsa_window.sv
module gsa_window
    import gsa_pkg::*;
#(
    parameter  int CLASSES = 4,
    parameter  int WINDOW  = 5,
    localparam int SUM_W   = SCORE_W + $clog2(WINDOW)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  score_t                  scores [SCORE_FIELDS],
    output logic                    sum_valid,
    input  logic                    sum_ready,
    output logic signed [SUM_W-1:0] sums [CLASSES]
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    score_t                  win_reg [WINDOW][CLASSES];
    score_t                  class_score [CLASSES];
    logic [SLOT_W-1:0]       slot_reg;
    logic                    sum_valid_reg;
    logic signed [SUM_W-1:0] sum_reg  [CLASSES];
    logic signed [SUM_W-1:0] sum_next [CLASSES];
    logic                    accept;

    assign in_ready  = !sum_valid_reg || sum_ready;
    assign accept    = in_valid && in_ready;
    assign sum_valid = sum_valid_reg;
    assign sums      = sum_reg;

    // classes without an input field see a zero score
    for (genvar c = 0; c < CLASSES; c++)
    begin : g_class
        if (c < SCORE_FIELDS)
        begin : g_fed
            assign class_score[c] = scores[c];
        end
        else
        begin : g_zero
            assign class_score[c] = '0;
        end
    end

    always_comb
    begin
        for (int c = 0; c < CLASSES; c++)
        begin
            sum_next[c] = sum_reg[c] + SUM_W'(class_score[c]) - SUM_W'(win_reg[slot_reg][c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            sum_valid_reg <= 1'b0;
            for (int c = 0; c < CLASSES; c++)
            begin
                sum_reg[c] <= '0;
            end
            for (int k = 0; k < WINDOW; k++)
            begin
                for (int c = 0; c < CLASSES; c++)
                begin
                    win_reg[k][c] <= '0;
                end
            end
        end
        else
        begin
            if (accept)
            begin
                for (int c = 0; c < CLASSES; c++)
                begin
                    win_reg[slot_reg][c] <= class_score[c];
                    sum_reg[c]           <= sum_next[c];
                end
                slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            end

            if (accept)
            begin
                sum_valid_reg <= 1'b1;
            end
            else if (sum_ready)
            begin
                sum_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### rtl/core/gsa_divide.sv
module gsa_divide
    import gsa_pkg::*;
#(
    parameter  int CLASSES = 4,
    parameter  int WINDOW  = 5,
    localparam int SUM_W   = SCORE_W + $clog2(WINDOW)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sum_valid,
    output logic                    sum_ready,
    input  logic signed [SUM_W-1:0] sums [CLASSES],
    output logic                    avg_valid,
    input  logic                    avg_ready,
    output score_t                  avgs [CLASSES]
);

    // magnitude * RECIP >> SH is exact floor(magnitude / WINDOW) over the sum range
    localparam int         SH    = SUM_W + $clog2(WINDOW);
    localparam logic [SH:0] RECIP = (SH + 1)'(((1 << SH) + WINDOW - 1) / WINDOW);

    logic                  neg      [CLASSES];
    logic [SUM_W-1:0]      mag      [CLASSES];
    logic [SUM_W+SH:0]     prod     [CLASSES];
    logic [SCORE_W-1:0]    quo      [CLASSES];
    score_t                avg_next [CLASSES];
    score_t                avg_reg  [CLASSES];
    logic                  avg_valid_reg;
    logic                  load;

    assign sum_ready = !avg_valid_reg || avg_ready;
    assign load      = sum_valid && sum_ready;
    assign avg_valid = avg_valid_reg;
    assign avgs      = avg_reg;

    always_comb
    begin
        for (int c = 0; c < CLASSES; c++)
        begin
            neg[c]      = sums[c][SUM_W-1];
            mag[c]      = neg[c] ? SUM_W'(-sums[c]) : SUM_W'(sums[c]);
            prod[c]     = mag[c] * RECIP;
            quo[c]      = SCORE_W'(prod[c] >> SH);
            avg_next[c] = neg[c] ? score_t'(-quo[c]) : score_t'(quo[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            avg_valid_reg <= 1'b1;
        end
        else if (avg_ready)
        begin
            avg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            avg_reg <= avg_next;
        end
    end

endmodule

### rtl/core/gsa_select.sv
module gsa_select
    import gsa_pkg::*;
#(
    parameter int CLASSES = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         avg_valid,
    output logic         avg_ready,
    input  score_t       avgs [CLASSES],
    gsa_result_if.source result
);

    localparam int CLS_W = $clog2(CLASSES);
    localparam int IDX_W = (CLS_W > NONE_W) ? CLS_W : NONE_W;

    logic [IDX_W-1:0] best_idx;
    score_t           best_score;
    logic [7:0]       hold_reg;
    logic [7:0]       hold_dec;
    logic [7:0]       hold_next;
    logic             report;
    class_code_t      gesture_next;
    logic             out_valid_reg;
    class_code_t      gesture_reg;
    score_t           best_average_reg;
    logic             detected_reg;
    logic             load;

    assign avg_ready = !out_valid_reg || result.ready;
    assign load      = avg_valid && avg_ready;

    // scan from class 0 with score 0; only a strictly higher average wins
    always_comb
    begin
        best_idx   = '0;
        best_score = '0;
        for (int c = 0; c < CLASSES; c++)
        begin
            if (avgs[c] > best_score)
            begin
                best_idx   = IDX_W'(c);
                best_score = avgs[c];
            end
        end

        hold_dec     = (hold_reg != 8'd0) ? hold_reg - 8'd1 : hold_reg;
        report       = !((best_idx == IDX_W'(cfg.none_class)) ||
                         (best_score < $signed(cfg.detect_threshold)) ||
                         (hold_dec != 8'd0));
        hold_next    = report ? cfg.holdoff_length : hold_dec;
        gesture_next = report ? best_idx[NONE_W-1:0] : cfg.none_class;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hold_reg      <= '0;
        end
        else
        begin
            if (load)
            begin
                hold_reg <= hold_next;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            gesture_reg      <= gesture_next;
            best_average_reg <= best_score;
            detected_reg     <= report;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.gesture      = gesture_reg;
    assign result.best_average = best_average_reg;
    assign result.detected     = detected_reg;

endmodule

### rtl/core/gesture_score_averager.sv
// Gesture score averager. Each item carries one signed score per class; the
// block keeps a ring of the last WINDOW scores and a running sum per class,
// averages each sum (truncated toward zero), picks the class with the highest
// positive average and reports it unless it is the no-gesture class, is below
// the threshold or a hold-off from the previous report is still running. One
// item is taken every cycle while the result is not stalled. The result passes
// window update, reciprocal divide and selection, one register stage each; a
// stalled result holds the pipeline and, once all three stages are full, the
// input. Running sums and the hold-off counter feed back through their own
// registers. Control state and the window are cleared at reset with no
// clearing pass. Configuration is written through cfg_write/cfg_index/cfg_data
// while no item is in flight, which the user must ensure; the block does not.
module gesture_score_averager
    import gsa_pkg::*;
#(
    parameter int CLASSES = 4,
    parameter int WINDOW  = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    gsa_score_if.sink        scores,
    gsa_result_if.source     result
);

    localparam int SUM_W = SCORE_W + $clog2(WINDOW);

    cfg_t                    cfg_reg;
    score_t                  score_arr [SCORE_FIELDS];
    logic                    sum_valid;
    logic                    sum_ready;
    logic signed [SUM_W-1:0] sums [CLASSES];
    logic                    avg_valid;
    logic                    avg_ready;
    score_t                  avgs [CLASSES];

    assign score_arr[0] = scores.score_0;
    assign score_arr[1] = scores.score_1;
    assign score_arr[2] = scores.score_2;
    assign score_arr[3] = scores.score_3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detect_threshold <= RST_DETECT_THRESHOLD;
            cfg_reg.holdoff_length   <= RST_HOLDOFF_LENGTH;
            cfg_reg.none_class       <= RST_NONE_CLASS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DETECT_THRESHOLD: cfg_reg.detect_threshold <= score_t'(cfg_data);
                CFG_HOLDOFF_LENGTH:   cfg_reg.holdoff_length   <= cfg_data;
                CFG_NONE_CLASS:       cfg_reg.none_class       <= cfg_data[NONE_W-1:0];
                default:              ;
            endcase
        end
    end

    gsa_window #(
        .CLASSES (CLASSES),
        .WINDOW  (WINDOW)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scores.valid),
        .in_ready  (scores.ready),
        .scores    (score_arr),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sums      (sums)
    );

    gsa_divide #(
        .CLASSES (CLASSES),
        .WINDOW  (WINDOW)
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sums      (sums),
        .avg_valid (avg_valid),
        .avg_ready (avg_ready),
        .avgs      (avgs)
    );

    gsa_select #(
        .CLASSES (CLASSES)
    ) u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .avg_valid (avg_valid),
        .avg_ready (avg_ready),
        .avgs      (avgs),
        .result    (result)
    );

endmodule

### rtl/core/gsa_checker.sv
`include "gesture_score_averager_assert.svh"

module gsa_checker
    import gsa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input class_code_t gesture,
    input score_t      best_average,
    input logic        detected
);

    // no result item may be shown while reset is held
    `GSA_ASSERT_ALWAYS(a_no_result_in_reset, clk, !rst_n |-> !result_valid)

    // the best-average scan starts at zero, so it never reports a negative value
    `GSA_ASSERT(a_best_average_nonneg, clk, rst_n, result_valid |-> !best_average[SCORE_W-1])

    `GSA_ASSERT(a_result_held, clk, rst_n, result_valid && !result_ready |=> result_valid && $stable(gesture) && $stable(best_average) && $stable(detected))

endmodule

bind gesture_score_averager gsa_checker u_gsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .gesture      (result.gesture),
    .best_average (result.best_average),
    .detected     (result.detected)
);

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import gsa_pkg::*;

    localparam int CLASSES      = 4;
    localparam int WINDOW       = 5;
    localparam int PHASE_ITEMS  = 200;
    localparam int STALL_CYCLES = 160;
    localparam int QUIET_LIMIT  = 2000;

    // index with no register behind it
    localparam cfg_index_t CFG_SPARE = 2'd3;

    typedef struct packed {
        score_t score_3;
        score_t score_2;
        score_t score_1;
        score_t score_0;
    } score_item_t;

    typedef struct packed {
        class_code_t gesture;
        score_t      best_average;
        logic        detected;
    } verdict_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b1;
    logic             cfg_write = 1'b0;
    cfg_index_t       cfg_index = CFG_DETECT_THRESHOLD;
    logic [CFG_W-1:0] cfg_data = '0;

    gsa_score_if  score_ch ();
    gsa_result_if result_ch ();

    gesture_score_averager uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scores    (score_ch),
        .result    (result_ch)
    );

    // mirror of the averager
    score_t      window_ring [CLASSES][WINDOW];
    int          class_sum [CLASSES];
    int          ring_pos;
    int          holdoff_left;
    score_t      threshold_cfg;
    logic [7:0]  holdoff_cfg;
    class_code_t none_cfg;

    score_item_t sender_pending [$];
    verdict_t    expected_verdicts [$];
    int          items_queued = 0;
    int          items_taken = 0;
    int          results_seen = 0;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    bit          stall_done = 1'b0;
    bit          offer_taken = 1'b0;
    logic        steady;

    assign steady = (items_taken >= 600) && (items_taken < 900);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic verdict_t predict_verdict(score_item_t item);
        verdict_t v;
        score_t   s [CLASSES];
        int       avg;
        int       best_cls;
        int       best_avg;
        bit       report;
        s[0] = item.score_0;
        s[1] = item.score_1;
        s[2] = item.score_2;
        s[3] = item.score_3;
        for (int c = 0; c < CLASSES; c++)
        begin
            class_sum[c] += int'(s[c]) - int'(window_ring[c][ring_pos]);
            window_ring[c][ring_pos] = s[c];
        end
        ring_pos = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
        best_cls = 0;
        best_avg = 0;
        for (int c = 0; c < CLASSES; c++)
        begin
            avg = class_sum[c] / WINDOW;
            if (avg > best_avg)
            begin
                best_cls = c;
                best_avg = avg;
            end
        end
        if (holdoff_left > 0)
            holdoff_left--;
        report = !(best_cls == int'(none_cfg) || best_avg < int'(threshold_cfg) ||
                   holdoff_left > 0);
        if (report)
            holdoff_left = int'(holdoff_cfg);
        v.gesture      = report ? class_code_t'(best_cls) : none_cfg;
        v.best_average = score_t'(best_avg);
        v.detected     = report;
        return v;
    endfunction

    // hot < 0: noise over the full range; otherwise one class leads
    function automatic score_item_t make_item(int hot);
        score_t s [CLASSES];
        for (int c = 0; c < CLASSES; c++)
        begin
            if (hot < 0)
                s[c] = score_t'($urandom_range(0, 255));
            else if (c == hot)
                s[c] = score_t'($urandom_range(70, 127));
            else
                s[c] = score_t'(int'($urandom_range(0, 170)) - 128);
        end
        return {s[3], s[2], s[1], s[0]};
    endfunction

    task automatic queue_item(score_item_t item);
        sender_pending.push_back(item);
        items_queued++;
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic apply_setting(score_t thr, logic [7:0] hold, class_code_t none);
        write_reg(CFG_DETECT_THRESHOLD, thr);
        write_reg(CFG_HOLDOFF_LENGTH, hold);
        write_reg(CFG_NONE_CLASS, {6'($urandom_range(0, 63)), none});
        write_reg(CFG_SPARE, 8'($urandom_range(0, 255)));
        @(negedge clk);
        cfg_write <= 1'b0;
        threshold_cfg = thr;
        holdoff_cfg   = hold;
        none_cfg      = none;
    endtask

    task automatic wait_idle();
        while (items_taken != items_queued || expected_verdicts.size() != 0)
            @(negedge clk);
    endtask

    // sender
    always @(negedge clk)
    begin : drive_scores
        score_item_t nxt;
        if (!rst_n)
            score_ch.valid <= 1'b0;
        else if (!score_ch.valid || offer_taken)
        begin
            if (sender_pending.size() != 0 && (steady || $urandom_range(99) >= 22))
            begin
                nxt = sender_pending.pop_front();
                score_ch.score_0 <= nxt.score_0;
                score_ch.score_1 <= nxt.score_1;
                score_ch.score_2 <= nxt.score_2;
                score_ch.score_3 <= nxt.score_3;
                score_ch.valid   <= 1'b1;
            end
            else
                score_ch.valid <= 1'b0;
        end
    end

    // receiver, with one long hold-off once results are flowing
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else if (!stall_done && results_seen >= 300)
        begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= steady || $urandom_range(99) >= 22;
    end

    always @(posedge clk)
    begin : check_results
        verdict_t want;
        offer_taken = rst_n && score_ch.valid && score_ch.ready;
        if (offer_taken)
        begin
            expected_verdicts.push_back(predict_verdict({score_ch.score_3, score_ch.score_2,
                                                         score_ch.score_1, score_ch.score_0}));
            items_taken++;
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (expected_verdicts.size() == 0)
            begin
                $error("unexpected result: gesture %0d best_average %0d detected %0b",
                       result_ch.gesture, result_ch.best_average, result_ch.detected);
                mismatch_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (result_ch.gesture !== want.gesture)
                begin
                    $error("gesture: expected %0d, got %0d", want.gesture, result_ch.gesture);
                    mismatch_count++;
                end
                if (result_ch.best_average !== want.best_average)
                begin
                    $error("best_average: expected %0d, got %0d",
                           want.best_average, result_ch.best_average);
                    mismatch_count++;
                end
                if (result_ch.detected !== want.detected)
                begin
                    $error("detected: expected %0b, got %0b", want.detected,
                           result_ch.detected);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((score_ch.valid && score_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          pat [5][4];
        int          thr_set [5];
        int          hold_set [5];
        int          none_set [5];
        int          left;
        int          hot;
        int          run;
        score_t      thr;
        logic [7:0]  hold;
        class_code_t none;

        pat      = '{'{-128, -128, -128, -128}, '{127, -128, 0, 127}, '{-128, 127, 1, -1},
                     '{0, 0, -128, 127}, '{1, 2, 100, 0}};
        thr_set  = '{-128, 127, 0, 50, 80};
        hold_set = '{0, 255, 1, 5, 25};
        none_set = '{0, 3, 1, 2, 3};

        score_ch.valid   = 1'b0;
        score_ch.score_0 = '0;
        score_ch.score_1 = '0;
        score_ch.score_2 = '0;
        score_ch.score_3 = '0;
        result_ch.ready  = 1'b0;

        for (int c = 0; c < CLASSES; c++)
        begin
            class_sum[c] = 0;
            for (int k = 0; k < WINDOW; k++)
                window_ring[c][k] = '0;
        end
        ring_pos      = 0;
        holdoff_left  = 0;
        threshold_cfg = RST_DETECT_THRESHOLD;
        holdoff_cfg   = RST_HOLDOFF_LENGTH;
        none_cfg      = RST_NONE_CLASS;

        // a real falling edge on reset before the first clock edge
        #1 rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: saturated scores, ties, none class leading, hold-off
        for (int i = 0; i < 5; i++)
            repeat (5)
                queue_item({score_t'(pat[i][3]), score_t'(pat[i][2]),
                            score_t'(pat[i][1]), score_t'(pat[i][0])});
        wait_idle();

        for (int p = 0; p < 9; p++)
        begin
            if (p < 5)
            begin
                thr  = score_t'(thr_set[p]);
                hold = 8'(hold_set[p]);
                none = class_code_t'(none_set[p]);
            end
            else
            begin
                thr  = score_t'($urandom_range(0, 255));
                hold = 8'($urandom_range(0, 30));
                none = class_code_t'($urandom_range(0, 3));
            end
            apply_setting(thr, hold, none);
            left = PHASE_ITEMS;
            while (left > 0)
            begin
                if ($urandom_range(99) < 70)
                begin
                    hot = $urandom_range(0, CLASSES - 1);
                    run = $urandom_range(3, 12);
                end
                else
                begin
                    hot = -1;
                    run = $urandom_range(1, 6);
                end
                for (int k = 0; k < run && left > 0; k++)
                begin
                    queue_item(make_item(hot));
                    left--;
                end
            end
            wait_idle();
        end

        repeat (6) @(negedge clk);
        if (mismatch_count == 0 && expected_verdicts.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
